FILE: hw/rtl/hbs_pkg.sv
// hbs_pkg: types, codes and constants for the hypercolumn bilinear sampler
// used by hbs_ctrl, hbs_dp and hypercolumn_bilinear_sampler_unit
package hbs_pkg;

	localparam int DEF_MAX_WIDTH    = 64;
	localparam int DEF_MAX_HEIGHT   = 64;
	localparam int DEF_MAX_CHANNELS = 16;
	localparam int RESULT_LIMIT     = 16;

	localparam int DIV_STEPS    = 12;
	localparam int FDIV_STEPS   = 16;
	localparam int NB_COUNT     = 4;
	localparam int DRAIN_CYCLES = 2;
	localparam int ACC_W        = 56;

	typedef struct packed {
		logic               action;
		logic [3:0]         load_channel;
		logic [5:0]         load_row;
		logic [5:0]         load_col;
		logic signed [15:0] load_value;
		logic [10:0]        point_x;
		logic [10:0]        point_y;
	} in_word_t;

	typedef struct packed {
		logic [3:0]         out_channel;
		logic signed [15:0] feature;
		logic               last;
	} out_word_t;

	typedef enum logic [1:0] {
		CFG_POOL     = 2'd0,
		CFG_WIDTH    = 2'd1,
		CFG_HEIGHT   = 2'd2,
		CFG_CHANNELS = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_GEO,
		ST_AXS,
		ST_WPROD,
		ST_RD,
		ST_DRAIN,
		ST_FINIT,
		ST_FDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load_wr;
		logic       query_load;
		logic       div_step;
		logic       geo;
		logic       axs;
		logic       wprod;
		logic       rd;
		logic [1:0] nb;
		logic       acc_clr;
		logic       finit;
		logic       fdiv_step;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic last_ch;
	} stat_t;

endpackage

FILE: hw/rtl/hbs_ctrl.sv
// hbs_ctrl: sequencer of the sampler, drives the datapath by command word
// depends on hbs_pkg
module hbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          action,
	input  hbs_pkg::stat_t stat,
	output hbs_pkg::cmd_t  cmd,
	output logic          busy
);
	import hbs_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 4'd0 : cnt_q + 4'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start && action) state_d = ST_DIV;
			ST_DIV:   if (cnt_q == 4'(DIV_STEPS - 1)) state_d = ST_GEO;
			ST_GEO:   state_d = ST_AXS;
			ST_AXS:   state_d = ST_WPROD;
			ST_WPROD: state_d = ST_RD;
			ST_RD:    if (cnt_q == 4'(NB_COUNT - 1)) state_d = ST_DRAIN;
			ST_DRAIN: if (cnt_q == 4'(DRAIN_CYCLES - 1)) state_d = ST_FINIT;
			ST_FINIT: state_d = ST_FDIV;
			ST_FDIV:  if (cnt_q == 4'(FDIV_STEPS - 1)) state_d = ST_EMIT;
			ST_EMIT:  state_d = stat.last_ch ? ST_IDLE : ST_RD;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.nb         = cnt_q[1:0];
		cmd.load_wr    = (state_q == ST_IDLE) && start && !action;
		cmd.query_load = (state_q == ST_IDLE) && start && action;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.geo        = (state_q == ST_GEO);
		cmd.axs        = (state_q == ST_AXS);
		cmd.wprod      = (state_q == ST_WPROD);
		cmd.rd         = (state_q == ST_RD);
		cmd.acc_clr    = (state_q == ST_WPROD) || (state_q == ST_EMIT);
		cmd.finit      = (state_q == ST_FINIT);
		cmd.fdiv_step  = (state_q == ST_FDIV);
		cmd.emit       = (state_q == ST_EMIT);
		busy           = (state_q != ST_IDLE);
	end

endmodule

FILE: hw/rtl/hbs_dp.sv
// hbs_dp: feature store, coordinate divider, weights, multiply-accumulate
// and rounding divider of the sampler; depends on hbs_pkg
module hbs_dp #(
	parameter int MAX_WIDTH    = hbs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = hbs_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = hbs_pkg::DEF_MAX_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hbs_pkg::in_word_t in_word,
	input  logic [5:0]        pool_e,
	input  logic [6:0]        w_e,
	input  logic [6:0]        h_e,
	input  logic [4:0]        nch_e,
	input  hbs_pkg::cmd_t     cmd,
	output hbs_pkg::stat_t    stat,
	output logic              result_valid,
	output hbs_pkg::out_word_t result
);
	import hbs_pkg::*;

	localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	logic signed [15:0] mem [DEPTH];

	logic [6:0]  dd;
	logic [12:0] nx_c, ny_c;
	logic signed [12:0] nx_q, ny_q;
	logic [6:0]  xr_q, yr_q;
	logic [11:0] xd_q, yd_q;
	logic [7:0]  rx2, ry2;
	logic signed [12:0] fx, fy, fx1, fy1, wlim, hlim;
	logic [6:0]  x1_q, x2_q, y1_q, y2_q;
	logic [11:0] pp_q;
	logic [14:0] m_q;
	logic signed [15:0] ax_q, ay_q;
	logic signed [15:0] wx1, wx2, wy1, wy2;
	logic signed [31:0] wgt_q [NB_COUNT];
	logic [3:0]  ch_q;
	logic [6:0]  rrow, rcol;
	logic [AW-1:0] raddr, waddr;
	logic signed [15:0] rdata_s1;
	logic [1:0]  nb_s1;
	logic        v_s1, v_s2;
	logic signed [47:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q, np;
	logic        sat_hi_q, sat_lo_q;
	logic [30:0] fr_q;
	logic [29:0] fd_q;
	logic [15:0] fq_q;
	logic        wr_ok;
	logic        result_valid_q;
	out_word_t   result_q;

	assign dd   = {pool_e, 1'b0};
	assign nx_c = 13'({1'b0, in_word.point_x, 1'b0}) - 13'(pool_e) + 13'd1;
	assign ny_c = 13'({1'b0, in_word.point_y, 1'b0}) - 13'(pool_e) + 13'd1;
	assign rx2  = {xr_q, xd_q[11]};
	assign ry2  = {yr_q, yd_q[11]};

	assign fx   = nx_q[12] ? -13'sd1 : $signed({1'b0, xd_q});
	assign fy   = ny_q[12] ? -13'sd1 : $signed({1'b0, yd_q});
	assign fx1  = fx + 13'sd1;
	assign fy1  = fy + 13'sd1;
	assign wlim = $signed(13'(w_e)) - 13'sd1;
	assign hlim = $signed(13'(h_e)) - 13'sd1;

	assign wx2 = ax_q;
	assign wy2 = ay_q;
	assign wx1 = $signed(16'(dd)) - ax_q;
	assign wy1 = $signed(16'(dd)) - ay_q;

	assign rrow  = cmd.nb[0] ? y2_q : y1_q;
	assign rcol  = cmd.nb[1] ? x2_q : x1_q;
	assign raddr = AW'((32'(ch_q) * MAX_HEIGHT + 32'(rrow)) * MAX_WIDTH + 32'(rcol));
	assign waddr = AW'((32'(in_word.load_channel) * MAX_HEIGHT + 32'(in_word.load_row))
		* MAX_WIDTH + 32'(in_word.load_col));
	assign wr_ok = (32'(in_word.load_channel) < MAX_CHANNELS)
		&& (32'(in_word.load_row) < MAX_HEIGHT) && (32'(in_word.load_col) < MAX_WIDTH);

	assign np = (acc_q <<< 1) + $signed(ACC_W'({pp_q, 2'b00}))
		+ $signed(ACC_W'({m_q, 15'b0}));

	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_ok) begin
			mem[waddr] <= in_word.load_value;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// coordinate division, clamping, weights and neighbour products
	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			nx_q <= $signed(nx_c);
			ny_q <= $signed(ny_c);
			xr_q <= '0;
			yr_q <= '0;
			xd_q <= nx_c[11:0];
			yd_q <= ny_c[11:0];
		end else if (cmd.div_step) begin
			if (rx2 >= {1'b0, dd}) begin
				xr_q <= 7'(rx2 - {1'b0, dd});
				xd_q <= {xd_q[10:0], 1'b1};
			end else begin
				xr_q <= rx2[6:0];
				xd_q <= {xd_q[10:0], 1'b0};
			end
			if (ry2 >= {1'b0, dd}) begin
				yr_q <= 7'(ry2 - {1'b0, dd});
				yd_q <= {yd_q[10:0], 1'b1};
			end else begin
				yr_q <= ry2[6:0];
				yd_q <= {yd_q[10:0], 1'b0};
			end
		end
		if (cmd.geo) begin
			x1_q <= (fx < 13'sd0) ? 7'd0 : (fx > wlim) ? 7'(wlim) : 7'(fx);
			x2_q <= (fx1 > wlim) ? 7'(wlim) : 7'(fx1);
			y1_q <= (fy < 13'sd0) ? 7'd0 : (fy > hlim) ? 7'(hlim) : 7'(fy);
			y2_q <= (fy1 > hlim) ? 7'(hlim) : 7'(fy1);
			pp_q <= 12'(pool_e * pool_e);
		end
		if (cmd.axs) begin
			ax_q <= $signed(16'(nx_q)) - $signed(16'(dd * x1_q));
			ay_q <= $signed(16'(ny_q)) - $signed(16'(dd * y1_q));
			m_q  <= {pp_q, 3'b000};
		end
		if (cmd.wprod) begin
			wgt_q[0] <= wy1 * wx1;
			wgt_q[1] <= wy2 * wx1;
			wgt_q[2] <= wy1 * wx2;
			wgt_q[3] <= wy2 * wx2;
		end
		nb_s1   <= cmd.nb;
		prod_s2 <= rdata_s1 * wgt_q[nb_s1];
	end

	// accumulate, round by restoring division, emit
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.finit) begin
			sat_lo_q <= np < 0;
			sat_hi_q <= np >= $signed(ACC_W'({m_q, 16'b0}));
			fr_q     <= np[30:0];
			fd_q     <= {m_q, 15'b0};
			fq_q     <= '0;
		end else if (cmd.fdiv_step) begin
			if (fr_q >= {1'b0, fd_q}) begin
				fr_q <= fr_q - {1'b0, fd_q};
				fq_q <= {fq_q[14:0], 1'b1};
			end else begin
				fq_q <= {fq_q[14:0], 1'b0};
			end
			fd_q <= fd_q >> 1;
		end
		if (cmd.emit) begin
			result_q.out_channel <= ch_q;
			result_q.last        <= stat.last_ch;
			result_q.feature     <= sat_hi_q ? 16'sh7fff : sat_lo_q ? -16'sh8000
				: $signed({~fq_q[15], fq_q[14:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			ch_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1           <= cmd.rd;
			v_s2           <= v_s1;
			result_valid_q <= cmd.emit;
			if (cmd.query_load) begin
				ch_q <= '0;
			end else if (cmd.emit) begin
				ch_q <= ch_q + 4'd1;
			end
		end
	end

	assign stat.last_ch = ({1'b0, ch_q} + 5'd1) == nch_e;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: hw/rtl/hypercolumn_bilinear_sampler_unit.sv
// hypercolumn_bilinear_sampler_unit: top level, configuration registers,
// controller and datapath; depends on hbs_pkg, hbs_ctrl, hbs_dp
//
// usage: an input word is taken at a clock edge with start high and busy low.
// a load word (action 0) writes one feature value into the store; busy stays
// low. a query word (action 1) raises busy and produces one result word per
// channel, each shown for one cycle with result_valid high; the word with last
// set is the final one and busy is already low then. a query runs coordinate
// division, then clamping and weights, then per channel the store reads of the
// four neighbours through the single read port, the pipeline drain, a division
// setup step, a 16-step rounding division and the emit cycle; each result word
// shows in the cycle after its emit cycle.
// the receiver cannot stall: every result word must be taken when shown.
// configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, the block itself does not enforce this.
// reset returns the controller to idle and the registers to pool 1, 64 by 64,
// 16 channels; the feature store is not cleared and must be loaded first.
module hypercolumn_bilinear_sampler_unit #(
	parameter int MAX_WIDTH    = hbs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = hbs_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = hbs_pkg::DEF_MAX_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  hbs_pkg::in_word_t   in_word,
	output logic                result_valid,
	output hbs_pkg::out_word_t  result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data
);
	import hbs_pkg::*;

	localparam int CH_LIMIT = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

	logic [5:0] pool_q;
	logic [6:0] width_q, height_q;
	logic [4:0] chans_q;
	logic [5:0] pool_e;
	logic [6:0] w_e, h_e;
	logic [4:0] nch_e;
	cmd_t       cmd;
	stat_t      stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= 6'd1;
			width_q  <= 7'd64;
			height_q <= 7'd64;
			chans_q  <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_POOL:     pool_q   <= cfg_data[5:0];
				CFG_WIDTH:    width_q  <= cfg_data;
				CFG_HEIGHT:   height_q <= cfg_data;
				CFG_CHANNELS: chans_q  <= cfg_data[4:0];
				default:      pool_q   <= pool_q;
			endcase
		end
	end

	always_comb begin
		pool_e = (pool_q == 6'd0) ? 6'd1 : pool_q;
		w_e    = (width_q == 7'd0) ? 7'd1
			: (11'(width_q) > 11'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_q;
		h_e    = (height_q == 7'd0) ? 7'd1
			: (11'(height_q) > 11'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_q;
		nch_e  = (chans_q == 5'd0) ? 5'd1
			: (7'(chans_q) > 7'(CH_LIMIT)) ? 5'(CH_LIMIT) : chans_q;
	end

	hbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (in_word.action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	hbs_dp #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_word      (in_word),
		.pool_e       (pool_e),
		.w_e          (w_e),
		.h_e          (h_e),
		.nch_e        (nch_e),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word outside a query");
	a_last_ends_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("busy after last result word");
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !in_word.action |=> !busy)
		else $error("load word raised busy");
	a_result_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result words back to back");
`endif

endmodule

FILE: sim/tb_hypercolumn_bilinear_sampler_unit.sv
// tb_hypercolumn_bilinear_sampler_unit: self-checking testbench for the bilinear
// feature sampler; preloads a corner of the store, runs directed and random words
// under several register settings; depends on hbs_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb_hypercolumn_bilinear_sampler_unit;
	import hbs_pkg::*;

	localparam int MW = DEF_MAX_WIDTH;
	localparam int MH = DEF_MAX_HEIGHT;
	localparam int MC = DEF_MAX_CHANNELS;
	localparam int FILL = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t in_word = '0;
	logic result_valid;
	out_word_t result;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	hypercolumn_bilinear_sampler_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	typedef struct {
		in_word_t w;
		bit       typed;
		logic signed [15:0] feat;
	} dir_row_t;

	logic signed [15:0] feat_mem [MC*MH*MW];
	logic [5:0] pool_r = 6'd1;
	logic [6:0] width_r = 7'd64;
	logic [6:0] height_r = 7'd64;
	logic [4:0] chans_r = 5'd16;
	out_word_t pending_words[$];
	int errors = 0;
	bit next_typed = 0;
	logic signed [15:0] next_feat;
	bit idle_on = 1;

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint size_of(longint v, longint maxv);
		return v == 0 ? 1 : (v > maxv ? maxv : v);
	endfunction

	function automatic longint fetch(longint c, longint r, longint col);
		return longint'(feat_mem[(c*MH + r)*MW + col]);
	endfunction

	// blend of four clamped neighbors per channel, queued as expected words
	task automatic predict_samples(input logic [10:0] px, input logic [10:0] py);
		longint p, w, h, nch, d, nx, ny, fx, fy, x1, x2, y1, y2, ax, ay, s, r;
		out_word_t o;
		p = pool_r == 0 ? 1 : pool_r;
		w = size_of(width_r, MW);
		h = size_of(height_r, MH);
		nch = size_of(chans_r, MC);
		if (nch > RESULT_LIMIT) nch = RESULT_LIMIT;
		d = 2*p;
		nx = 2*longint'(px) - p + 1;
		ny = 2*longint'(py) - p + 1;
		fx = floor_quot(nx, d);
		fy = floor_quot(ny, d);
		x1 = clip(fx, 0, w-1);
		x2 = clip(fx+1, 0, w-1);
		y1 = clip(fy, 0, h-1);
		y2 = clip(fy+1, 0, h-1);
		ax = nx - d*x1;
		ay = ny - d*y1;
		for (longint c = 0; c < nch; c++) begin
			s = fetch(c, y1, x1)*(d-ay)*(d-ax) + fetch(c, y2, x1)*ay*(d-ax)
			  + fetch(c, y1, x2)*(d-ay)*ax + fetch(c, y2, x2)*ay*ax;
			r = clip(floor_quot(2*s + d*d, 2*d*d), -32768, 32767);
			o.out_channel = c[3:0];
			o.feature = r[15:0];
			o.last = (c == nch-1);
			pending_words = {pending_words, o};
		end
	endtask

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && start && !busy) begin
			if (!in_word.action)
				feat_mem[(int'(in_word.load_channel)*MH + in_word.load_row)*MW
					+ in_word.load_col] = in_word.load_value;
			else if (next_typed) begin
				e.out_channel = '0;
				e.feature = next_feat;
				e.last = 1'b1;
				pending_words = {pending_words, e};
			end else
				predict_samples(in_word.point_x, in_word.point_y);
		end
		if (arst_n && result_valid) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word %p", result);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (result.out_channel !== e.out_channel) begin
					$error("out_channel exp %0d got %0d", e.out_channel, result.out_channel);
					errors++;
				end
				if (result.feature !== e.feature) begin
					$error("feature exp %0d got %0d", e.feature, result.feature);
					errors++;
				end
				if (result.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, result.last);
					errors++;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(input in_word_t w, input int gap);
		bit free;
		start <= 1'b1;
		in_word <= w;
		do begin
			@(negedge clk);
			free = !busy;
			@(posedge clk);
		end while (!free);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_POOL:     pool_r = val[5:0];
			CFG_WIDTH:    width_r = val;
			CFG_HEIGHT:   height_r = val;
			CFG_CHANNELS: chans_r = val[4:0];
			default:      pool_r = pool_r;
		endcase
	endtask

	task automatic apply_cfg(input logic [6:0] p, input logic [6:0] w,
			input logic [6:0] h, input logic [6:0] c);
		cfg_write(CFG_POOL, p);
		cfg_write(CFG_WIDTH, w);
		cfg_write(CFG_HEIGHT, h);
		cfg_write(CFG_CHANNELS, c);
		cfg_we <= 1'b0;
	endtask

	function automatic in_word_t rand_word(input bit act);
		in_word_t w;
		int sel;
		int span;
		w.action = act;
		w.load_channel = 4'($urandom);
		w.load_row = 6'($urandom_range(0, FILL - 1));
		w.load_col = 6'($urandom_range(0, FILL - 1));
		sel = $urandom_range(0, 9);
		w.load_value = sel == 0 ? 16'sh7fff : (sel == 1 ? 16'sh8000 : 16'($urandom));
		span = (pool_r == 0 ? 1 : pool_r) * (width_r == 0 ? 1 : width_r) + 8;
		w.point_x = $urandom_range(0, 9) < 8 ? 11'($urandom_range(0, span)) : 11'($urandom);
		span = (pool_r == 0 ? 1 : pool_r) * (height_r == 0 ? 1 : height_r) + 8;
		w.point_y = $urandom_range(0, 9) < 8 ? 11'($urandom_range(0, span)) : 11'($urandom);
		return w;
	endfunction

	function automatic dir_row_t mk(input bit act, input int ch, input int row,
			input int col, input int val, input int px, input int py,
			input bit typed, input int feat);
		dir_row_t d;
		d.w.action = act;
		d.w.load_channel = 4'(ch);
		d.w.load_row = 6'(row);
		d.w.load_col = 6'(col);
		d.w.load_value = 16'(val);
		d.w.point_x = 11'(px);
		d.w.point_y = 11'(py);
		d.typed = typed;
		d.feat = 16'(feat);
		return d;
	endfunction

	initial begin
		in_word_t w;
		dir_row_t dir_tab[$];
		logic [6:0] phases [7][4];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the corner that small maps read, all channels
		for (int i = 0; i < MC*FILL*FILL; i++) begin
			w = rand_word(1'b0);
			w.load_channel = 4'(i / (FILL*FILL));
			w.load_row = 6'((i / FILL) % FILL);
			w.load_col = 6'(i % FILL);
			send(w, 0);
		end
		settle();

		// directed: one channel per query so typed values stand alone
		apply_cfg(7'd1, 7'd127, 7'd127, 7'd1);
		dir_tab = {dir_tab, mk(0, 0, 0, 0, 32767, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(1, 15, 63, 63, -1, 0, 0, 1, 32767)};
		dir_tab = {dir_tab, mk(0, 0, 63, 63, -32768, 2047, 2047, 0, 0)};
		dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 2047, 2047, 1, -32768)};
		dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 126, 126, 1, -32768)};
		dir_tab = {dir_tab, mk(0, 15, 63, 63, 12345, 2047, 0, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 0, 63, 777, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 1, 63, -4321, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 63, 0, 20000, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 63, 1, -9000, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(1, 15, 63, 63, 32767, 1, 0, 0, 0)};
		dir_tab = {dir_tab, mk(1, 0, 0, 0, -32768, 0, 1, 0, 0)};
		dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 1023, 1024, 0, 0)};
		dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 2047, 0, 0, 0)};
		dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 0, 2047, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 0, 1, 32767, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 1, 0, 32767, 0, 0, 0, 0)};
		dir_tab = {dir_tab, mk(0, 0, 1, 1, 32767, 0, 0, 0, 0)};
		foreach (dir_tab[i]) begin
			next_typed <= dir_tab[i].typed;
			next_feat <= dir_tab[i].feat;
			send(dir_tab[i].w, 0);
		end
		start <= 1'b0;
		@(posedge clk);
		next_typed <= 1'b0;
		settle();
		// far outside with a pool of 32, then a pool of zero
		apply_cfg(7'd32, 7'd3, 7'd3, 7'd16);
		send(mk(1, 0, 0, 0, 0, 0, 0, 0, 0).w, 0);
		send(mk(1, 0, 0, 0, 0, 2047, 2047, 0, 0).w, 0);
		send(mk(1, 0, 0, 0, 0, 16, 48, 0, 0).w, 0);
		settle();
		apply_cfg(7'd64, 7'd0, 7'd0, 7'd0);
		send(mk(1, 0, 0, 0, 0, 5, 9, 0, 0).w, 0);
		settle();

		phases = '{'{7'd1, 7'd3, 7'd3, 7'd16}, '{7'd32, 7'd1, 7'd1, 7'd1},
			'{7'd7, 7'd2, 7'd3, 7'd31}, '{7'd2, 7'd3, 7'd2, 7'd4},
			'{7'd0, 7'd0, 7'd0, 7'd0}, '{7'd3, 7'd3, 7'd1, 7'd17},
			'{7'd16, 7'd2, 7'd2, 7'd8}};
		foreach (phases[k]) begin
			apply_cfg(phases[k][0], phases[k][1], phases[k][2], phases[k][3]);
			idle_on = (k % 3) != 2;
			for (int i = 0; i < 12; i++)
				send(rand_word($urandom_range(0, 9) < 7), pick_gap());
			settle();
		end
		apply_cfg(7'($urandom_range(1, 32)), 7'($urandom_range(1, FILL)),
			7'($urandom_range(1, FILL)), 7'($urandom_range(1, 16)));
		for (int i = 0; i < 10; i++)
			send(rand_word(1'b1), pick_gap());
		settle();
		repeat (30) @(posedge clk);

		if (errors == 0 && pending_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
